@@ sv/tlbmmu_pkg.sv @@
package tlbmmu_pkg;
    localparam int ADDR_W = 16;
    localparam int OFFSET_W = 9;
    localparam int PAGE_W = ADDR_W - OFFSET_W;
    localparam int PAGES = 1 << PAGE_W;
    localparam int FRAME_W = 4;
    localparam int FRAMES = 1 << FRAME_W;
    localparam int TLB_N = 8;
    localparam int TLB_W = 3;
    localparam int TIME_W = 16;
    localparam int COST_W = 18;
    localparam int CNT_W = 32;
    localparam int TOT_W = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TLB_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_TIME = 2'd2;

    // High when a 32-bit count sits at its ceiling and must hold
    function automatic logic sat_max32(input logic [CNT_W-1:0] v);
        sat_max32 = &v;
    endfunction
endpackage

@@ sv/tlbmmu_ram.sv @@
module tlbmmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ sv/tlb_page_table_lru_mmu.sv @@
// TLB and demand-paging MMU with LRU replacement.
// Input channel: in_valid/in_stall carry req_type and address; an item is
// accepted when in_valid is high and in_stall low. in_stall stays high while
// an item is at work and while its result waits on the output.
// Output channel: out_valid/out_stall carry the frame, hit/fault/page-out
// flags, the access cost and the running saturating totals.
// Configuration: cfg_we/cfg_index/cfg_data write memory_time (0),
// tlb_time (1) and fault_time (2); other indexes are dropped.
// Steps from the accepting edge to out_valid: a TLB hit ends the TLB scan
// (one TLB entry compared per cycle); a TLB miss with the page
// resident takes the TLB scan, page table read, TLB victim scan and
// install; a fault into a free frame adds a frame scan, and a fault
// that evicts a resident page also adds a TLB invalidate pass.
// One item is in flight at a time: the next item is taken
// the cycle after the result is taken.
// Reset: a clearing pass invalidates every page table entry; no item is
// accepted meanwhile. TLB and frame tables clear at once.
// A stalled output holds its result; the next item waits until it is taken.
module tlb_page_table_lru_mmu
    import tlbmmu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [ADDR_W-1:0]     address,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [FRAME_W-1:0]    frame_number,
    output logic                  tlb_hit,
    output logic                  page_fault,
    output logic                  page_out,
    output logic [COST_W-1:0]     access_time,
    output logic [CNT_W-1:0]      hit_count,
    output logic [CNT_W-1:0]      page_in_count,
    output logic [CNT_W-1:0]      page_out_count,
    output logic [TOT_W-1:0]      total_time,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIME_W-1:0]     cfg_data
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_TSCAN = 4'd2;
    localparam logic [3:0] S_PTRD  = 4'd3;
    localparam logic [3:0] S_PTCHK = 4'd4;
    localparam logic [3:0] S_FSCAN = 4'd5;
    localparam logic [3:0] S_EVICT = 4'd6;
    localparam logic [3:0] S_INST  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_TVIC  = 4'd10;
    localparam logic [3:0] S_TWR   = 4'd11;

    logic [3:0] state_reg;
    logic [PAGE_W-1:0] clr_reg;
    logic [4:0] idx_reg;

    logic [TIME_W-1:0] mem_t_reg, tlb_t_reg, flt_t_reg;

    logic              tv_reg [TLB_N];
    logic [PAGE_W-1:0] tp_reg [TLB_N];
    logic [FRAME_W-1:0] tf_reg [TLB_N];
    logic [CNT_W-1:0]  tt_reg [TLB_N];

    logic [PAGE_W-1:0] fp_reg [FRAMES];
    logic              fd_reg [FRAMES];
    logic [CNT_W-1:0]  ft_reg [FRAMES];

    logic [CNT_W-1:0] clock_reg, hits_reg, pins_reg, pouts_reg;
    logic [TOT_W-1:0] tot_reg;

    logic              wr_reg;
    logic [PAGE_W-1:0] page_reg, old_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic              hit_reg, fault_reg, pout_reg, found_reg, evict_reg;
    logic [TLB_W-1:0]  pick_reg;
    logic [CNT_W-1:0]  best_reg;
    logic [COST_W-1:0] cost_reg;

    // page table memory: {valid, frame}
    logic              pt_we;
    logic [PAGE_W-1:0] pt_waddr, pt_raddr;
    logic [FRAME_W:0]  pt_wdata, pt_rdata;

    tlbmmu_ram #(.WIDTH(FRAME_W + 1), .DEPTH(PAGES)) u_pt (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    logic [TLB_W-1:0]   ti;
    logic [FRAME_W-1:0] fi;
    assign ti = idx_reg[TLB_W-1:0];
    assign fi = idx_reg[FRAME_W-1:0];

    assign in_stall = (state_reg != S_IDLE);
    assign pt_raddr = page_reg;

    always_comb
    begin
        pt_we = 1'b0;
        pt_waddr = page_reg;
        pt_wdata = {1'b1, frame_reg};
        if (state_reg == S_CLEAR)
        begin
            pt_we = 1'b1;
            pt_waddr = clr_reg;
            pt_wdata = '0;
        end
        else if (state_reg == S_EVICT && idx_reg == 5'd0 && evict_reg)
        begin
            pt_we = 1'b1;
            pt_waddr = old_reg;
            pt_wdata = '0;
        end
        else if (state_reg == S_INST && fault_reg)
        begin
            pt_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_t_reg <= '0;
            tlb_t_reg <= '0;
            flt_t_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MEMORY_TIME: mem_t_reg <= cfg_data;
                REG_TLB_TIME:    tlb_t_reg <= cfg_data;
                REG_FAULT_TIME:  flt_t_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [TOT_W:0] tot_sum;
    assign tot_sum = {1'b0, tot_reg} + {{(TOT_W + 1 - COST_W){1'b0}}, cost_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            idx_reg <= '0;
            for (int i = 0; i < TLB_N; i++)
            begin
                tv_reg[i] <= 1'b0;
                tt_reg[i] <= '0;
                tp_reg[i] <= '0;
                tf_reg[i] <= '0;
            end
            for (int i = 0; i < FRAMES; i++)
            begin
                fp_reg[i] <= '0;
                fd_reg[i] <= 1'b0;
                ft_reg[i] <= '0;
            end
            clock_reg <= 32'd1;
            hits_reg <= '0;
            pins_reg <= '0;
            pouts_reg <= '0;
            tot_reg <= '0;
            out_valid <= 1'b0;
            wr_reg <= 1'b0;
            page_reg <= '0;
            old_reg <= '0;
            frame_reg <= '0;
            hit_reg <= 1'b0;
            fault_reg <= 1'b0;
            pout_reg <= 1'b0;
            found_reg <= 1'b0;
            evict_reg <= 1'b0;
            pick_reg <= '0;
            best_reg <= '0;
            cost_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        wr_reg <= req_type;
                        page_reg <= address[ADDR_W-1:OFFSET_W];
                        hit_reg <= 1'b0;
                        fault_reg <= 1'b0;
                        pout_reg <= 1'b0;
                        found_reg <= 1'b0;
                        evict_reg <= 1'b0;
                        cost_reg <= {2'b0, tlb_t_reg};
                        idx_reg <= '0;
                        state_reg <= S_TSCAN;
                    end
                end
                S_TSCAN:
                begin
                    // one TLB entry compared per cycle
                    if (tv_reg[ti] && tp_reg[ti] == page_reg)
                    begin
                        hit_reg <= 1'b1;
                        frame_reg <= tf_reg[ti];
                        tt_reg[ti] <= clock_reg;
                        if (!sat_max32(hits_reg))
                        begin
                            hits_reg <= hits_reg + 1'b1;
                        end
                        state_reg <= S_DONE;
                    end
                    else if (idx_reg == 5'(TLB_N - 1))
                    begin
                        cost_reg <= cost_reg + {2'b0, mem_t_reg};
                        state_reg <= S_PTRD;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                S_PTRD:
                begin
                    state_reg <= S_PTCHK;
                end
                S_PTCHK:
                begin
                    idx_reg <= '0;
                    if (pt_rdata[FRAME_W])
                    begin
                        frame_reg <= pt_rdata[FRAME_W-1:0];
                        state_reg <= S_INST;
                    end
                    else
                    begin
                        fault_reg <= 1'b1;
                        cost_reg <= cost_reg + {2'b0, flt_t_reg};
                        frame_reg <= '0;
                        best_reg <= '1;
                        state_reg <= S_FSCAN;
                    end
                end
                S_FSCAN:
                begin
                    // one frame per cycle: first free, else strict minimum
                    if (!found_reg)
                    begin
                        if (ft_reg[fi] == '0)
                        begin
                            found_reg <= 1'b1;
                            frame_reg <= fi;
                        end
                        else if (idx_reg == 5'd0 || ft_reg[fi] < best_reg)
                        begin
                            best_reg <= ft_reg[fi];
                            frame_reg <= fi;
                        end
                    end
                    if (idx_reg == 5'(FRAMES - 1))
                    begin
                        state_reg <= S_EVICT;
                        idx_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_EVICT:
                begin
                    if (idx_reg == 5'd0 && !evict_reg)
                    begin
                        if (fd_reg[frame_reg])
                        begin
                            pout_reg <= 1'b1;
                            cost_reg <= cost_reg + {2'b0, flt_t_reg};
                            if (!sat_max32(pouts_reg))
                            begin
                                pouts_reg <= pouts_reg + 1'b1;
                            end
                        end
                        if (!sat_max32(pins_reg))
                        begin
                            pins_reg <= pins_reg + 1'b1;
                        end
                        old_reg <= fp_reg[frame_reg];
                        fp_reg[frame_reg] <= page_reg;
                        fd_reg[frame_reg] <= 1'b0;
                        if (ft_reg[frame_reg] != '0)
                        begin
                            evict_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_INST;
                        end
                    end
                    else
                    begin
                        if (tv_reg[ti] && tp_reg[ti] == old_reg)
                        begin
                            tv_reg[ti] <= 1'b0;
                        end
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 5'(TLB_N - 1))
                        begin
                            state_reg <= S_INST;
                        end
                    end
                end
                S_INST:
                begin
                    idx_reg <= '0;
                    best_reg <= '1;
                    found_reg <= 1'b0;
                    pick_reg <= '0;
                    state_reg <= S_TVIC;
                end
                S_TVIC:
                begin
                    // TLB victim: first invalid entry, else strict minimum
                    if (!found_reg)
                    begin
                        if (!tv_reg[ti])
                        begin
                            found_reg <= 1'b1;
                            pick_reg <= ti;
                        end
                        else if (idx_reg == 5'd0 || tt_reg[ti] < best_reg)
                        begin
                            best_reg <= tt_reg[ti];
                            pick_reg <= ti;
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == 5'(TLB_N - 1))
                    begin
                        state_reg <= S_TWR;
                    end
                end
                S_TWR:
                begin
                    tv_reg[pick_reg] <= 1'b1;
                    tp_reg[pick_reg] <= page_reg;
                    tf_reg[pick_reg] <= frame_reg;
                    tt_reg[pick_reg] <= clock_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (wr_reg)
                    begin
                        fd_reg[frame_reg] <= 1'b1;
                    end
                    ft_reg[frame_reg] <= clock_reg;
                    if (!sat_max32(clock_reg))
                    begin
                        clock_reg <= clock_reg + 1'b1;
                    end
                    tot_reg <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
                    out_valid <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign frame_number = frame_reg;
    assign tlb_hit = hit_reg;
    assign page_fault = fault_reg;
    assign page_out = pout_reg;
    assign access_time = cost_reg;
    assign hit_count = hits_reg;
    assign page_in_count = pins_reg;
    assign page_out_count = pouts_reg;
    assign total_time = tot_reg;

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT) else $error("result outside output state");
    a_hit_nofault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tlb_hit && page_fault)) else $error("hit with fault");
    a_pout_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && page_out) |-> page_fault) else $error("page out without fault");
endmodule
